// ===== hw/rtl/fcsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsd_pkg
// Shared types and constants of the framed command stream deframer.
// ----------------------------------------------------------------------------
package fcsd_pkg;

  localparam int TIME_BITS          = 32;
  localparam int MOTION_FRAME_BYTES = 12;
  localparam int MIN_RESET_LEN      = 6;
  localparam int CFG_IDX_BITS       = 3;
  localparam int CFG_DATA_BITS      = 16;
  localparam int QUEUE_DEPTH        = 2;
  localparam int QPTR_BITS          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_TAKE = 2'd2;

  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_MOTION = 2'd1;
  localparam logic [1:0] ST_RESET  = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_HEADER,
    CFG_MOTION_ADDR,
    CFG_RESET_ADDR,
    CFG_RESET_OPCODE,
    CFG_RESET_LEN,
    CFG_TIMEOUT
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_TICK,
    OP_TAKE,
    OP_IDLE
  } op_t;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_ADDR,
    PH_LEN,
    PH_BODY
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       buffer_end;
  } item_t;

  typedef struct packed {
    logic [31:0] velocity_bits;
    logic [31:0] turn_rate_bits;
    logic        command_online;
    logic [1:0]  frame_status;
    logic        reset_valid;
    logic [7:0]  reset_segment;
  } result_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic       buffer_end;
  } entry_t;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [7:0]  motion_address;
    logic [7:0]  reset_address;
    logic [7:0]  reset_opcode;
    logic [3:0]  reset_frame_length;
    logic [15:0] online_timeout;
  } cfg_t;

  typedef struct packed {
    logic [QCNT_BITS-1:0] count;
    logic                 full;
    logic                 empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fcsd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsd_front
// Input stage: takes transactions, decodes the command and registers the entry.
// ----------------------------------------------------------------------------
module fcsd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  wire fcsd_pkg::item_t cmd_data,
  output logic                 entry_valid,
  input  wire logic            entry_ready,
  output fcsd_pkg::entry_t     entry
);
  import fcsd_pkg::*;

  op_t op;

  always_comb begin
    unique case (cmd_data.command)
      CMD_BYTE: op = OP_BYTE;
      CMD_TICK: op = OP_TICK;
      CMD_TAKE: op = OP_TAKE;
      default:  op = OP_IDLE;
    endcase
  end

  assign cmd_ready = !entry_valid || entry_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (cmd_ready) begin
      entry_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      entry.op         <= op;
      entry.data_byte  <= cmd_data.data_byte;
      entry.buffer_end <= cmd_data.buffer_end;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fcsd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsd_queue
// Short FIFO of decoded entries between the front and the back.
// ----------------------------------------------------------------------------
module fcsd_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire fcsd_pkg::entry_t push_entry,
  input  wire logic             pop,
  output fcsd_pkg::entry_t      head,
  output fcsd_pkg::q_stat_t     stat
);
  import fcsd_pkg::*;

  entry_t               slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign stat.count = count;
  assign stat.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign head       = slots[rd_ptr];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fcsd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsd_back
// Frame parser, motion and reset request state, result register.
// ----------------------------------------------------------------------------
module fcsd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fcsd_pkg::cfg_t    cfg,
  input  wire fcsd_pkg::q_stat_t q_stat,
  input  wire fcsd_pkg::entry_t  head,
  output logic                   pop,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output fcsd_pkg::result_t      res_data
);
  import fcsd_pkg::*;

  phase_t               phase, phase_next;
  logic [7:0]           byte_pos, byte_pos_next;
  logic [7:0]           frame_size, frame_size_next;
  logic [7:0]           frame_addr, frame_addr_next;
  logic [7:0]           running_sum, running_sum_next;
  logic [31:0]          body_velocity, body_velocity_next;
  logic [31:0]          body_turn, body_turn_next;
  logic [7:0]           body_opcode, body_opcode_next;
  logic [7:0]           body_segment, body_segment_next;
  logic [31:0]          held_velocity, held_velocity_next;
  logic [31:0]          held_turn, held_turn_next;
  logic                 ever_received, ever_received_next;
  logic [TIME_BITS-1:0] elapsed, elapsed_next;
  logic                 pending_flag, pending_flag_next;
  logic [7:0]           pending_segment, pending_segment_next;
  logic [7:0]           previous_segment, previous_segment_next;
  logic                 segment_known, segment_known_next;

  logic [3:0]           min_len;
  logic [7:0]           b;
  logic                 sum_ok;
  logic [1:0]           status;
  logic                 took;
  logic [7:0]           seg;
  logic                 online;

  assign pop     = !q_stat.empty && (!res_valid || res_ready);
  assign b       = head.data_byte;
  assign min_len = (cfg.reset_frame_length < 4'(MIN_RESET_LEN)) ?
                   4'(MIN_RESET_LEN) : cfg.reset_frame_length;
  assign sum_ok  = (running_sum == b);

  always_comb begin
    phase_next            = phase;
    byte_pos_next         = byte_pos;
    frame_size_next       = frame_size;
    frame_addr_next       = frame_addr;
    running_sum_next      = running_sum;
    body_velocity_next    = body_velocity;
    body_turn_next        = body_turn;
    body_opcode_next      = body_opcode;
    body_segment_next     = body_segment;
    held_velocity_next    = held_velocity;
    held_turn_next        = held_turn;
    ever_received_next    = ever_received;
    elapsed_next          = elapsed;
    pending_flag_next     = pending_flag;
    pending_segment_next  = pending_segment;
    previous_segment_next = previous_segment;
    segment_known_next    = segment_known;
    status                = ST_NONE;
    took                  = 1'b0;
    seg                   = 8'd0;

    if (pop) begin
      unique case (head.op)
        OP_BYTE: begin
          unique case (phase)
            PH_HUNT: begin
              if (b == cfg.header_byte) begin
                running_sum_next = b;
                phase_next       = PH_ADDR;
              end
            end
            PH_ADDR: begin
              frame_addr_next  = b;
              running_sum_next = running_sum + b;
              phase_next       = PH_LEN;
            end
            PH_LEN: begin
              if (b < {4'd0, min_len}) begin
                // short length: rescan address then length for a header
                if (frame_addr == cfg.header_byte) begin
                  running_sum_next = frame_addr + b;
                  frame_addr_next  = b;
                  phase_next       = PH_LEN;
                end else if (b == cfg.header_byte) begin
                  running_sum_next = b;
                  phase_next       = PH_ADDR;
                end else begin
                  phase_next = PH_HUNT;
                end
              end else begin
                frame_size_next  = b;
                running_sum_next = running_sum + b;
                byte_pos_next    = 8'd3;
                phase_next       = PH_BODY;
              end
            end
            PH_BODY: begin
              if ({1'b0, byte_pos} + 9'd1 >= {1'b0, frame_size}) begin
                phase_next = PH_HUNT;
                if (frame_addr == cfg.motion_address) begin
                  if (frame_size != 8'(MOTION_FRAME_BYTES) || !sum_ok) begin
                    status = ST_REJECT;
                  end else begin
                    held_velocity_next = body_velocity;
                    held_turn_next     = body_turn;
                    elapsed_next       = '0;
                    ever_received_next = 1'b1;
                    status             = ST_MOTION;
                  end
                end else if (frame_addr == cfg.reset_address) begin
                  if (frame_size != {4'd0, min_len} || body_opcode != cfg.reset_opcode ||
                      !sum_ok) begin
                    status = ST_REJECT;
                  end else begin
                    if (!segment_known || body_segment != previous_segment) begin
                      previous_segment_next = body_segment;
                      pending_segment_next  = body_segment;
                      pending_flag_next     = 1'b1;
                      segment_known_next    = 1'b1;
                    end
                    status = ST_RESET;
                  end
                end else begin
                  status = ST_REJECT;
                end
              end else begin
                running_sum_next = running_sum + b;
                if (byte_pos == 8'd3) begin
                  body_opcode_next = b;
                end
                if (byte_pos == 8'd4) begin
                  body_segment_next = b;
                end
                case (byte_pos)
                  8'd3:    body_velocity_next[7:0]   = b;
                  8'd4:    body_velocity_next[15:8]  = b;
                  8'd5:    body_velocity_next[23:16] = b;
                  8'd6:    body_velocity_next[31:24] = b;
                  8'd7:    body_turn_next[7:0]       = b;
                  8'd8:    body_turn_next[15:8]      = b;
                  8'd9:    body_turn_next[23:16]     = b;
                  8'd10:   body_turn_next[31:24]     = b;
                  default: ;
                endcase
                byte_pos_next = byte_pos + 8'd1;
              end
            end
            default: phase_next = PH_HUNT;
          endcase
          // partial frame dropped at end of buffer
          if (head.buffer_end) begin
            phase_next = PH_HUNT;
          end
        end
        OP_TICK: begin
          elapsed_next = elapsed + 1'b1;
        end
        OP_TAKE: begin
          if (pending_flag) begin
            took              = 1'b1;
            seg               = pending_segment;
            pending_flag_next = 1'b0;
          end
        end
        default: ;
      endcase
    end

    online = ever_received_next && (elapsed_next <= TIME_BITS'(cfg.online_timeout));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      byte_pos         <= '0;
      frame_size       <= '0;
      frame_addr       <= '0;
      running_sum      <= '0;
      body_velocity    <= '0;
      body_turn        <= '0;
      body_opcode      <= '0;
      body_segment     <= '0;
      held_velocity    <= '0;
      held_turn        <= '0;
      ever_received    <= 1'b0;
      elapsed          <= '0;
      pending_flag     <= 1'b0;
      pending_segment  <= '0;
      previous_segment <= '0;
      segment_known    <= 1'b0;
    end else begin
      phase            <= phase_next;
      byte_pos         <= byte_pos_next;
      frame_size       <= frame_size_next;
      frame_addr       <= frame_addr_next;
      running_sum      <= running_sum_next;
      body_velocity    <= body_velocity_next;
      body_turn        <= body_turn_next;
      body_opcode      <= body_opcode_next;
      body_segment     <= body_segment_next;
      held_velocity    <= held_velocity_next;
      held_turn        <= held_turn_next;
      ever_received    <= ever_received_next;
      elapsed          <= elapsed_next;
      pending_flag     <= pending_flag_next;
      pending_segment  <= pending_segment_next;
      previous_segment <= previous_segment_next;
      segment_known    <= segment_known_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_data.velocity_bits  <= held_velocity_next;
      res_data.turn_rate_bits <= held_turn_next;
      res_data.command_online <= online;
      res_data.frame_status   <= status;
      res_data.reset_valid    <= took;
      res_data.reset_segment  <= seg;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/framed_command_stream_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// framed_command_stream_deframer
// Byte stream frame parser for motion and odometry reset command frames.
// ----------------------------------------------------------------------------
// path: each accepted transaction passes the input register at the accepting edge,
//   then a queue slot, then the result register, where its result becomes valid
// throughput: one transaction per cycle while res_ready stays high; the parser handles one entry per pop
// reset: synchronous; parser to header search, all frame and request state to
//   zero, registers to their defaults (frame length 6, timeout 100 ms)
module framed_command_stream_deframer (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cmd_valid,
  output logic                                       cmd_ready,
  input  wire fcsd_pkg::item_t                       cmd_data,
  output logic                                       res_valid,
  input  wire logic                                  res_ready,
  output fcsd_pkg::result_t                          res_data,
  input  wire logic                                  cfg_write,
  input  wire logic [fcsd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [fcsd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import fcsd_pkg::*;

  cfg_t    cfg;
  entry_t  front_entry;
  logic    front_valid;
  entry_t  head;
  q_stat_t q_stat;
  logic    pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte        <= 8'd0;
      cfg.motion_address     <= 8'd0;
      cfg.reset_address      <= 8'd0;
      cfg.reset_opcode       <= 8'd0;
      cfg.reset_frame_length <= 4'd6;
      cfg.online_timeout     <= 16'd100;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_HEADER:       cfg.header_byte        <= cfg_data[7:0];
        CFG_MOTION_ADDR:  cfg.motion_address     <= cfg_data[7:0];
        CFG_RESET_ADDR:   cfg.reset_address      <= cfg_data[7:0];
        CFG_RESET_OPCODE: cfg.reset_opcode       <= cfg_data[7:0];
        CFG_RESET_LEN:    cfg.reset_frame_length <= cfg_data[3:0];
        CFG_TIMEOUT:      cfg.online_timeout     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  fcsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd_data    (cmd_data),
    .entry_valid (front_valid),
    .entry_ready (!q_stat.full),
    .entry       (front_entry)
  );

  fcsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (front_valid),
    .push_entry (front_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  fcsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  a_take_no_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_data.reset_valid && res_data.frame_status != ST_NONE))
    else $error("take result carries a frame status");

  a_segment_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_data.reset_valid) |-> res_data.reset_segment == 8'd0)
    else $error("segment id without a take");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue overfilled");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== test/framed_command_stream_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_command_stream_deframer_tb
// Streams bytes, millisecond ticks and request takes into the deframer under
// several register settings and random idling on both channels. It predicts
// every result transaction in step with the accepted input transactions and
// checks each field in arrival order.
// ----------------------------------------------------------------------------
module framed_command_stream_deframer_tb;
  import fcsd_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     cmd_valid = 1'b0;
  logic                     cmd_ready;
  item_t                    cmd_data  = '0;
  logic                     res_valid;
  logic                     res_ready = 1'b0;
  result_t                  res_data;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

  framed_command_stream_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // deframer mirror state
  cfg_t        cur_cfg     = {8'h00, 8'h00, 8'h00, 8'h00, 4'd6, 16'd100};
  phase_t      parse_phase = PH_HUNT;
  logic [7:0]  byte_pos    = '0;
  logic [7:0]  frame_size  = '0;
  logic [7:0]  frame_addr  = '0;
  logic [7:0]  run_sum     = '0;
  logic [31:0] body_vel    = '0;
  logic [31:0] body_turn   = '0;
  logic [7:0]  body_op     = '0;
  logic [7:0]  body_seg    = '0;
  logic [31:0] held_vel    = '0;
  logic [31:0] held_turn   = '0;
  logic        ever_rx     = 1'b0;
  logic [31:0] arrival_ms  = '0;
  logic [31:0] now_ms      = '0;
  logic        pend        = 1'b0;
  logic [7:0]  pend_seg    = '0;
  logic [7:0]  prev_seg    = '0;
  logic        seg_known   = 1'b0;

  result_t     expected_results[$];
  result_t     exp_res;
  bit          idle_on     = 1'b1;
  int          items_sent  = 0;
  int          error_count = 0;
  int          idle_cycles = 0;

  function automatic logic [7:0] frame_min_len();
    return (cur_cfg.reset_frame_length < 4'd6) ? 8'd6 : {4'd0, cur_cfg.reset_frame_length};
  endfunction

  function automatic result_t deframe_model(item_t it);
    result_t    r;
    logic [1:0] status;
    logic [7:0] b;
    logic [7:0] min_len;
    r       = '0;
    status  = ST_NONE;
    b       = it.data_byte;
    min_len = frame_min_len();
    case (op_t'(it.command))
      OP_BYTE: begin
        case (parse_phase)
          PH_HUNT: begin
            if (b == cur_cfg.header_byte) begin
              run_sum     = b;
              parse_phase = PH_ADDR;
            end
          end
          PH_ADDR: begin
            frame_addr  = b;
            run_sum     = run_sum + b;
            parse_phase = PH_LEN;
          end
          PH_LEN: begin
            if (b < min_len) begin
              // short length, rescan address then length byte
              if (frame_addr == cur_cfg.header_byte) begin
                run_sum    = frame_addr + b;
                frame_addr = b;
              end else if (b == cur_cfg.header_byte) begin
                run_sum     = b;
                parse_phase = PH_ADDR;
              end else begin
                parse_phase = PH_HUNT;
              end
            end else begin
              frame_size  = b;
              run_sum     = run_sum + b;
              byte_pos    = 8'd3;
              parse_phase = PH_BODY;
            end
          end
          PH_BODY: begin
            if (int'(byte_pos) + 1 >= int'(frame_size)) begin
              if (frame_addr == cur_cfg.motion_address) begin
                if (frame_size != MOTION_FRAME_BYTES || run_sum != b) begin
                  status = ST_REJECT;
                end else begin
                  held_vel   = body_vel;
                  held_turn  = body_turn;
                  arrival_ms = now_ms;
                  ever_rx    = 1'b1;
                  status     = ST_MOTION;
                end
              end else if (frame_addr == cur_cfg.reset_address) begin
                if (frame_size != min_len || body_op != cur_cfg.reset_opcode ||
                    run_sum != b) begin
                  status = ST_REJECT;
                end else begin
                  if (!seg_known || body_seg != prev_seg) begin
                    prev_seg  = body_seg;
                    pend_seg  = body_seg;
                    pend      = 1'b1;
                    seg_known = 1'b1;
                  end
                  status = ST_RESET;
                end
              end else begin
                status = ST_REJECT;
              end
              parse_phase = PH_HUNT;
            end else begin
              run_sum = run_sum + b;
              if (byte_pos == 8'd3) body_op = b;
              if (byte_pos == 8'd4) body_seg = b;
              if (byte_pos >= 8'd3 && byte_pos <= 8'd6) begin
                body_vel[8*(int'(byte_pos)-3) +: 8] = b;
              end else if (byte_pos >= 8'd7 && byte_pos <= 8'd10) begin
                body_turn[8*(int'(byte_pos)-7) +: 8] = b;
              end
              byte_pos = byte_pos + 8'd1;
            end
          end
        endcase
        if (it.buffer_end) parse_phase = PH_HUNT;
      end
      OP_TICK: now_ms = now_ms + 32'd1;
      OP_TAKE: begin
        if (pend) begin
          r.reset_valid   = 1'b1;
          r.reset_segment = pend_seg;
          pend            = 1'b0;
        end
      end
      default: ;
    endcase
    r.velocity_bits  = held_vel;
    r.turn_rate_bits = held_turn;
    r.command_online = ever_rx && ((now_ms - arrival_ms) <= 32'(cur_cfg.online_timeout));
    r.frame_status   = status;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready) expected_results.push_back(deframe_model(cmd_data));
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result with none expected, actual %0h", $time, res_data);
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          compare_field("velocity_bits", exp_res.velocity_bits, res_data.velocity_bits);
          compare_field("turn_rate_bits", exp_res.turn_rate_bits, res_data.turn_rate_bits);
          compare_field("command_online", exp_res.command_online, res_data.command_online);
          compare_field("frame_status", exp_res.frame_status, res_data.frame_status);
          compare_field("reset_valid", exp_res.reset_valid, res_data.reset_valid);
          compare_field("reset_segment", exp_res.reset_segment, res_data.reset_segment);
        end
      end
    end
  end

  always @(negedge clk) begin
    res_ready <= !idle_on || ($urandom_range(99) >= 23);
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [7:0] b, logic last);
    while (idle_on && $urandom_range(99) < 23) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= {cmd, b, last};
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_frame(logic [7:0] addr, logic [7:0] len, logic [7:0] opcode,
                            logic [7:0] seg, bit bad_sum, int cut_at);
    logic [7:0] bytes[$];
    logic [7:0] sum;
    int         n;
    n     = (len < 8'd3) ? 3 : int'(len);
    bytes = {cur_cfg.header_byte, addr, len};
    for (int i = 3; i < n - 1; i++) begin
      bytes.push_back((i == 3) ? opcode : (i == 4) ? seg : 8'($urandom));
    end
    if (n > 3) begin
      sum = '0;
      foreach (bytes[i]) sum = sum + bytes[i];
      bytes.push_back(sum + 8'(bad_sum));
    end
    for (int i = 0; i < bytes.size(); i++) begin
      send_item(CMD_BYTE, bytes[i],
                (i == cut_at) || (i == bytes.size() - 1 && $urandom_range(7) == 0));
      if (i == cut_at) break;
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  task automatic apply_settings(cfg_t c);
    cmd_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(CFG_HEADER, 16'(c.header_byte));
    write_reg(CFG_MOTION_ADDR, 16'(c.motion_address));
    write_reg(CFG_RESET_ADDR, 16'(c.reset_address));
    write_reg(CFG_RESET_OPCODE, 16'(c.reset_opcode));
    write_reg(CFG_RESET_LEN, 16'(c.reset_frame_length));
    write_reg(CFG_TIMEOUT, c.online_timeout);
    cfg_write <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic test_register_defaults;
    // motion and reset addresses both zero, motion wins
    send_frame(8'h00, 8'd12, 8'h12, 8'h34, 1'b0, -1);
    send_item(CMD_TICK, 8'h00, 1'b0);
    send_frame(8'h00, 8'd6, 8'h00, 8'h01, 1'b0, -1);
  endtask

  task automatic test_motion_frames;
    apply_settings({8'hAA, 8'h11, 8'h22, 8'h5A, 4'd6, 16'd5});
    send_frame(8'h11, 8'd12, 8'hFF, 8'h00, 1'b0, -1);
    repeat (6) send_item(CMD_TICK, 8'hFF, 1'b1);
    send_frame(8'h11, 8'd12, 8'h00, 8'hFF, 1'b1, -1);
    send_frame(8'h11, 8'd13, 8'h00, 8'h00, 1'b0, -1);
    send_frame(8'h44, 8'd6, 8'h5A, 8'h00, 1'b0, -1);
  endtask

  task automatic test_reset_requests;
    send_item(CMD_TAKE, 8'h00, 1'b0);
    send_frame(8'h22, 8'd6, 8'h5A, 8'h03, 1'b0, -1);
    send_item(CMD_TAKE, 8'hFF, 1'b0);
    send_item(CMD_TAKE, 8'h00, 1'b1);
    // repeated segment id is accepted but raises nothing
    send_frame(8'h22, 8'd6, 8'h5A, 8'h03, 1'b0, -1);
    send_item(CMD_TAKE, 8'h00, 1'b0);
    send_frame(8'h22, 8'd6, 8'h5B, 8'hFF, 1'b0, -1);
    send_frame(8'h22, 8'd6, 8'h5A, 8'hFF, 1'b0, -1);
    send_item(CMD_TAKE, 8'h00, 1'b0);
  endtask

  task automatic test_short_length;
    apply_settings({8'h03, 8'h11, 8'h22, 8'h5A, 4'd0, 16'd0});
    send_item(CMD_BYTE, 8'h03, 1'b0);
    send_item(CMD_BYTE, 8'h03, 1'b0);
    send_item(CMD_BYTE, 8'h02, 1'b0);
    send_frame(8'h11, 8'd12, 8'h01, 8'h02, 1'b0, -1);
    send_item(CMD_BYTE, 8'h03, 1'b0);
    send_item(CMD_BYTE, 8'h07, 1'b0);
    send_frame(8'h22, 8'd6, 8'h5A, 8'h09, 1'b0, -1);
    send_item(CMD_BYTE, 8'h03, 1'b0);
    send_item(CMD_BYTE, 8'h07, 1'b0);
    send_item(CMD_BYTE, 8'h02, 1'b0);
    send_item(2'(OP_IDLE), 8'hFF, 1'b1);
  endtask

  task automatic test_buffer_end;
    send_frame(8'h11, 8'd12, 8'h00, 8'h00, 1'b0, 5);
    send_frame(8'h11, 8'd12, 8'h00, 8'h00, 1'b0, 1);
    send_frame(8'h11, 8'd12, 8'h00, 8'h00, 1'b0, 2);
    send_frame(8'h11, 8'd12, 8'h00, 8'h00, 1'b0, 10);
    send_frame(8'h11, 8'd12, 8'h00, 8'h00, 1'b0, -1);
  endtask

  task automatic test_shared_address;
    apply_settings({8'hFF, 8'h33, 8'h33, 8'hFF, 4'd15, 16'hFFFF});
    send_frame(8'h33, 8'd15, 8'hFF, 8'h07, 1'b0, -1);
    send_frame(8'h33, 8'd12, 8'h00, 8'h00, 1'b0, -1);
    apply_settings({8'h00, 8'h33, 8'h33, 8'h00, 4'd12, 16'hFFFF});
    send_frame(8'h33, 8'd12, 8'h00, 8'h07, 1'b0, -1);
  endtask

  task automatic test_random_traffic(int count);
    int         target;
    int         pick;
    logic [7:0] seg;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      seg  = $urandom_range(1) ? 8'($urandom_range(0, 2)) : 8'($urandom);
      if (pick < 40) begin
        send_frame(cur_cfg.motion_address, 8'd12, 8'($urandom), seg, 1'b0, -1);
      end else if (pick < 62) begin
        send_frame(cur_cfg.reset_address, frame_min_len(), cur_cfg.reset_opcode, seg,
                   1'b0, -1);
      end else if (pick < 68) begin
        send_frame($urandom_range(1) ? cur_cfg.motion_address : cur_cfg.reset_address,
                   $urandom_range(1) ? 8'd12 : frame_min_len(), cur_cfg.reset_opcode, seg,
                   1'b1, -1);
      end else if (pick < 72) begin
        send_frame(8'($urandom), 8'($urandom_range(frame_min_len(), 20)), 8'($urandom), seg,
                   1'b0, -1);
      end else if (pick < 76) begin
        send_frame(cur_cfg.motion_address, 8'd12, 8'($urandom), seg, 1'b0,
                   $urandom_range(0, 10));
      end else if (pick < 80) begin
        send_item(CMD_BYTE, cur_cfg.header_byte, 1'b0);
        send_item(CMD_BYTE, $urandom_range(1) ? cur_cfg.header_byte : 8'($urandom), 1'b0);
        send_item(CMD_BYTE, 8'($urandom_range(0, int'(frame_min_len()) - 1)), 1'b0);
        if ($urandom_range(1)) send_frame(cur_cfg.motion_address, 8'd12, 8'($urandom), seg,
                                          1'b0, -1);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 8)) send_item(CMD_TICK, 8'($urandom), 1'($urandom));
      end else if (pick < 94) begin
        send_item(CMD_TAKE, 8'($urandom), 1'($urandom));
      end else if (pick < 97) begin
        send_item(CMD_BYTE, 8'($urandom), 1'($urandom));
      end else begin
        send_item(2'(OP_IDLE), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_register_defaults();
    test_motion_frames();
    test_reset_requests();
    test_short_length();
    test_buffer_end();
    test_shared_address();
    apply_settings({8'hA5, 8'h01, 8'h02, 8'h7E, 4'd6, 16'd10});
    test_random_traffic(130);
    idle_on = 1'b0;
    apply_settings({8'h00, 8'hFF, 8'h80, 8'h00, 4'd12, 16'd0});
    test_random_traffic(130);
    idle_on = 1'b1;
    apply_settings({8'hFF, 8'h33, 8'h33, 8'hFF, 4'd15, 16'hFFFF});
    test_random_traffic(130);
    apply_settings({8'h03, 8'h40, 8'h41, 8'h0F, 4'd0, 16'd3});
    test_random_traffic(130);
    apply_settings({8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    4'($urandom_range(0, 15)), 16'($urandom_range(0, 30))});
    test_random_traffic(130);
    cmd_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fcsd_pkg.sv
hw/rtl/fcsd_front.sv
hw/rtl/fcsd_queue.sv
hw/rtl/fcsd_back.sv
hw/rtl/framed_command_stream_deframer.sv
test/framed_command_stream_deframer_tb.sv
